FILE: sv/prnf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the padded radix number formatter.
// No dependencies; the other files that use it refer to this package by scoped names.
package prnf_pkg;

   // Default sizes for the top-level parameters.
   localparam int VALUE_BITS_DEF  = 64;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Precision and width saturate here so a conversion never exceeds 64 characters.
   localparam logic [5:0] MAX_FIELD = 6'd62;

   localparam logic [4:0] RADIX_MIN = 5'd8;
   localparam logic [4:0] RADIX_MAX = 5'd16;

   localparam int COUNT_W = 7;

   localparam logic [7:0] ASCII_SPACE   = 8'h20;
   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_LOWER_X = 8'h78;
   localparam logic [7:0] ASCII_UPPER_X = 8'h58;
   localparam logic [7:0] ASCII_NUL     = 8'h00;

   typedef enum logic [1:0] {
      KIND_PLAIN   = 2'd0,
      KIND_LOWER_X = 2'd1,
      KIND_UPPER_X = 2'd2,
      KIND_POINTER = 2'd3
   } prnf_kind_type;

   // Layout of one conversion: each count field is the character position where a
   // segment ends (leading spaces, prefix, zeros, digits, then trailing spaces).
   typedef struct packed {
      logic [COUNT_W-1:0] lead_end;
      logic [COUNT_W-1:0] pfx_end;
      logic [COUNT_W-1:0] zero_end;
      logic [COUNT_W-1:0] digit_end;
      logic [COUNT_W-1:0] total;
      logic               upper_digits;
      logic               upper_x;
   } prnf_ctl_type;

endpackage

FILE: sv/prnf_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the padded radix number formatter.
// Depends on prnf_pkg for default sizes and the count width.
interface prnf_req_if #(
   parameter int VALUE_BITS = prnf_pkg::VALUE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic [4:0]            radix;
   logic                  upper_digits;
   logic [1:0]            conv_kind;
   logic                  alt_form;
   logic                  left_align;
   logic                  zero_pad;
   logic                  has_precision;
   logic [5:0]            precision;
   logic [5:0]            field_width;

   modport source (
      output valid, value, radix, upper_digits, conv_kind, alt_form, left_align,
             zero_pad, has_precision, precision, field_width,
      input  ready
   );
   modport sink (
      input  valid, value, radix, upper_digits, conv_kind, alt_form, left_align,
             zero_pad, has_precision, precision, field_width,
      output ready
   );
endinterface

interface prnf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [7:0]                     character;
   logic                           is_empty;
   logic                           is_last;
   logic [prnf_pkg::COUNT_W-1:0]   total_count;

   modport source (
      output valid, character, is_empty, is_last, total_count,
      input  ready
   );
   modport sink (
      input  valid, character, is_empty, is_last, total_count,
      output ready
   );
endinterface

FILE: sv/prnf_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, converts the value to digits by long division
// a byte per cycle, and lays out the text segments. Depends on prnf_pkg, prnf_if.
module prnf_front #(
   parameter int VALUE_BITS = prnf_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   prnf_req_if.sink                      req_ch,
   output logic                          push_valid,
   output prnf_pkg::prnf_ctl_type        push_ctl,
   output logic [((VALUE_BITS+2)/3)*4-1:0] push_digits,
   input  logic                          queue_full
);

   localparam int NCHUNK      = (VALUE_BITS + 7) / 8;
   localparam int NB          = NCHUNK * 8;
   localparam int CHUNK_W     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int BOUND_W     = $clog2(VALUE_BITS + 1);
   localparam int DIGITS      = (VALUE_BITS + 2) / 3;
   localparam int DIDX_W      = $clog2(DIGITS);
   localparam int NDIG_W      = $clog2(DIGITS + 1);
   localparam int CW          = prnf_pkg::COUNT_W;
   localparam logic [CHUNK_W-1:0] CHUNK_START = CHUNK_W'((VALUE_BITS - 1) / 8);
   localparam logic [BOUND_W-1:0] BOUND_START = BOUND_W'(VALUE_BITS);

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_PUSH} state_type;

   typedef struct packed {
      logic [4:0]              radix;
      logic                    upper_digits;
      prnf_pkg::prnf_kind_type kind;
      logic                    alt_form;
      logic                    left_align;
      logic                    zero_pad;
      logic                    has_precision;
      logic [5:0]              precision;
      logic [5:0]              field_width;
      logic                    is_zero;
   } opts_type;

   state_type             state_ff, state_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic [VALUE_BITS-1:0] hold_value_ff, hold_value_in;
   opts_type              hold_opts_ff, hold_opts_in;
   opts_type              job_ff, job_in;
   logic [NB-1:0]         num_ff, num_in;
   logic [4:0]            rem_ff, rem_in;
   logic [CHUNK_W-1:0]    chunk_ff, chunk_in;
   logic [BOUND_W-1:0]    bound_ff, bound_in;
   logic [NDIG_W-1:0]     ndig_ff, ndig_in;
   logic [3:0]            digit_ff [DIGITS];
   logic [3:0]            digit_in [DIGITS];

   logic [7:0]            div_quo;
   logic [4:0]            div_rem;
   logic [NB-1:0]         num_step;
   logic                  take;
   logic                  accept;
   opts_type              cap_opts;
   logic [BOUND_W-1:0]    bound_next;
   logic [BOUND_W-1:0]    bound_less;

   assign req_ch.ready = !hold_valid_ff;
   assign accept       = req_ch.valid && !hold_valid_ff;

   // Clamp radix, precision and width on capture.
   always_comb begin
      cap_opts.radix = req_ch.radix;
      if (req_ch.radix < prnf_pkg::RADIX_MIN) begin
         cap_opts.radix = prnf_pkg::RADIX_MIN;
      end else if (req_ch.radix > prnf_pkg::RADIX_MAX) begin
         cap_opts.radix = prnf_pkg::RADIX_MAX;
      end
      cap_opts.upper_digits  = req_ch.upper_digits;
      cap_opts.kind          = prnf_pkg::prnf_kind_type'(req_ch.conv_kind);
      cap_opts.alt_form      = req_ch.alt_form;
      cap_opts.left_align    = req_ch.left_align;
      cap_opts.zero_pad      = req_ch.zero_pad;
      cap_opts.has_precision = req_ch.has_precision;
      cap_opts.precision     = (req_ch.precision > prnf_pkg::MAX_FIELD) ?
                               prnf_pkg::MAX_FIELD : req_ch.precision;
      cap_opts.field_width   = (req_ch.field_width > prnf_pkg::MAX_FIELD) ?
                               prnf_pkg::MAX_FIELD : req_ch.field_width;
      cap_opts.is_zero       = (req_ch.value == '0);
   end

   // One byte of restoring long division by the radix.
   always_comb begin
      logic [4:0] r;
      logic [7:0] chunk_bits;
      r          = rem_ff;
      chunk_bits = num_ff[chunk_ff*8 +: 8];
      div_quo    = '0;
      for (int i = 7; i >= 0; i--) begin
         r = {r[3:0], chunk_bits[i]};
         if (r >= job_ff.radix) begin
            r          = r - job_ff.radix;
            div_quo[i] = 1'b1;
         end
      end
      div_rem = r;
      num_step = num_ff;
      num_step[chunk_ff*8 +: 8] = div_quo;
   end

   // Quotient shrinks by at least three bits per digit since the radix is 8 or more.
   assign bound_less = bound_ff - BOUND_W'(3);
   assign bound_next = (bound_ff > BOUND_W'(3)) ? bound_less : BOUND_W'(1);

   always_comb begin
      logic [BOUND_W-1:0] bound_m1;
      state_in      = state_ff;
      hold_valid_in = hold_valid_ff;
      hold_value_in = hold_value_ff;
      hold_opts_in  = hold_opts_ff;
      job_in        = job_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      chunk_in      = chunk_ff;
      bound_in      = bound_ff;
      ndig_in       = ndig_ff;
      digit_in      = digit_ff;
      take          = 1'b0;
      bound_m1      = bound_next - BOUND_W'(1);

      if (accept) begin
         hold_valid_in = 1'b1;
         hold_value_in = req_ch.value;
         hold_opts_in  = cap_opts;
      end

      unique case (state_ff)
         ST_IDLE: begin
            take = hold_valid_ff;
         end
         ST_DIVIDE: begin
            num_in = num_step;
            rem_in = div_rem;
            if (chunk_ff == '0) begin
               digit_in[ndig_ff[DIDX_W-1:0]] = div_rem[3:0];
               ndig_in = ndig_ff + NDIG_W'(1);
               rem_in  = '0;
               if (num_step == '0) begin
                  state_in = ST_PUSH;
               end else begin
                  bound_in = bound_next;
                  chunk_in = CHUNK_W'(bound_m1 >> 3);
               end
            end else begin
               chunk_in = chunk_ff - CHUNK_W'(1);
            end
         end
         ST_PUSH: begin
            if (!queue_full) begin
               take     = hold_valid_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (take) begin
         state_in      = ST_DIVIDE;
         hold_valid_in = 1'b0;
         job_in        = hold_opts_ff;
         num_in        = NB'(hold_value_ff);
         rem_in        = '0;
         chunk_in      = CHUNK_START;
         bound_in      = BOUND_START;
         ndig_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
      end
      hold_value_ff <= hold_value_in;
      hold_opts_ff  <= hold_opts_in;
      job_ff        <= job_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      chunk_ff      <= chunk_in;
      bound_ff      <= bound_in;
      ndig_ff       <= ndig_in;
      digit_ff      <= digit_in;
   end

   // Segment layout of the finished conversion.
   always_comb begin
      logic          show;
      logic          prefix;
      logic          zfill_on;
      logic          lead_on;
      logic [CW-1:0] len;
      logic [CW-1:0] prec;
      logic [CW-1:0] width;
      logic [CW-1:0] pad;
      logic [CW-1:0] pfx;
      logic [CW-1:0] body;
      logic [CW-1:0] fill;
      show   = !(job_ff.is_zero && job_ff.has_precision && job_ff.precision == '0 &&
                 job_ff.kind != prnf_pkg::KIND_POINTER);
      len    = show ? CW'(ndig_ff) : '0;
      prec   = CW'(job_ff.precision);
      width  = CW'(job_ff.field_width);
      pad    = (job_ff.has_precision && prec > len) ? prec - len : '0;
      prefix = (job_ff.kind == prnf_pkg::KIND_POINTER) ||
               (job_ff.alt_form && !job_ff.is_zero &&
                (job_ff.kind == prnf_pkg::KIND_LOWER_X ||
                 job_ff.kind == prnf_pkg::KIND_UPPER_X));
      pfx    = prefix ? CW'(2) : '0;
      body   = len + pad + pfx;
      fill   = (width > body) ? width - body : '0;
      zfill_on = !job_ff.left_align && job_ff.zero_pad && !job_ff.has_precision;
      lead_on  = !job_ff.left_align && !(job_ff.zero_pad && !job_ff.has_precision);
      push_ctl.lead_end     = lead_on ? fill : '0;
      push_ctl.pfx_end      = push_ctl.lead_end + pfx;
      push_ctl.zero_end     = push_ctl.pfx_end + pad + (zfill_on ? fill : '0);
      push_ctl.digit_end    = push_ctl.zero_end + len;
      push_ctl.total        = push_ctl.digit_end + (job_ff.left_align ? fill : '0);
      push_ctl.upper_digits = job_ff.upper_digits;
      push_ctl.upper_x      = (job_ff.kind == prnf_pkg::KIND_UPPER_X);
   end

   assign push_valid = (state_ff == ST_PUSH) && !queue_full;

   for (genvar g = 0; g < DIGITS; g++) begin : g_pack
      assign push_digits[g*4 +: 4] = digit_ff[g];
   end

endmodule

FILE: sv/prnf_queue.sv
`timescale 1ns / 1ps
// Short register queue between the front end and the character emitter.
// No package dependencies.
module prnf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/prnf_back.sv
`timescale 1ns / 1ps
// Back end: walks the queued conversion one character per cycle, as long as rsp_ch
// accepts, into the response output register. Depends on prnf_pkg and prnf_if.
module prnf_back #(
   parameter int VALUE_BITS = prnf_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  prnf_pkg::prnf_ctl_type          head_ctl,
   input  logic [((VALUE_BITS+2)/3)*4-1:0] head_digits,
   input  logic                            head_empty,
   output logic                            pop,
   prnf_rsp_if.source                      rsp_ch
);

   localparam int DIGITS = (VALUE_BITS + 2) / 3;
   localparam int DIDX_W = $clog2(DIGITS);
   localparam int CW     = prnf_pkg::COUNT_W;

   logic [CW-1:0] pos_ff, pos_in;
   logic          valid_ff, valid_in;
   logic [7:0]    char_ff, char_in;
   logic          empty_ff, empty_in;
   logic          last_ff, last_in;
   logic [CW-1:0] count_ff, count_in;

   logic          advance;
   logic          emit;
   logic          last;
   logic [CW-1:0] didx_full;
   logic [3:0]    digit;
   logic [7:0]    digit_char;
   logic [7:0]    cur_char;

   assign advance   = !valid_ff || rsp_ch.ready;
   assign emit      = advance && !head_empty;
   assign last      = (head_ctl.total == '0) || (pos_ff + CW'(1) == head_ctl.total);
   assign pop       = emit && last;

   assign didx_full = head_ctl.digit_end - CW'(1) - pos_ff;
   assign digit     = head_digits[didx_full[DIDX_W-1:0]*4 +: 4];

   always_comb begin
      if (digit < 4'd10) begin
         digit_char = prnf_pkg::ASCII_ZERO + {4'b0000, digit};
      end else begin
         digit_char = (head_ctl.upper_digits ? prnf_pkg::ASCII_UPPER_A :
                       prnf_pkg::ASCII_LOWER_A) + {4'b0000, digit} - 8'd10;
      end
   end

   always_comb begin
      priority if (head_ctl.total == '0) begin
         cur_char = prnf_pkg::ASCII_NUL;
      end else if (pos_ff < head_ctl.lead_end) begin
         cur_char = prnf_pkg::ASCII_SPACE;
      end else if (pos_ff < head_ctl.pfx_end) begin
         if (pos_ff == head_ctl.lead_end) begin
            cur_char = prnf_pkg::ASCII_ZERO;
         end else begin
            cur_char = head_ctl.upper_x ? prnf_pkg::ASCII_UPPER_X : prnf_pkg::ASCII_LOWER_X;
         end
      end else if (pos_ff < head_ctl.zero_end) begin
         cur_char = prnf_pkg::ASCII_ZERO;
      end else if (pos_ff < head_ctl.digit_end) begin
         cur_char = digit_char;
      end else begin
         cur_char = prnf_pkg::ASCII_SPACE;
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      empty_in = empty_ff;
      last_in  = last_ff;
      count_in = count_ff;
      if (emit) begin
         valid_in = 1'b1;
         char_in  = cur_char;
         empty_in = (head_ctl.total == '0);
         last_in  = last;
         count_in = last ? head_ctl.total : '0;
         pos_in   = last ? '0 : pos_ff + CW'(1);
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
      char_ff  <= char_in;
      empty_ff <= empty_in;
      last_ff  <= last_in;
      count_ff <= count_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.character   = char_ff;
   assign rsp_ch.is_empty    = empty_ff;
   assign rsp_ch.is_last     = last_ff;
   assign rsp_ch.total_count = count_ff;

endmodule

FILE: sv/padded_radix_number_formatter_top.sv
`timescale 1ns / 1ps
// Padded radix number formatter: prints an unsigned value as printf-style text.
// Uses prnf_pkg, prnf_if, prnf_front, prnf_queue and prnf_back.
//
// req_ch takes one request: value, radix (8..16, clamped), digit case, kind
// (plain, x, X, p), hash/minus/zero flags, precision and field width (both
// saturate at 62). rsp_ch returns the text one character per response; the
// final response carries is_last and the total character count. A conversion
// that prints nothing returns a single response flagged is_empty.
// The front end divides the value by the radix a byte per cycle, one digit per
// pass over the quotient; passes shrink as the quotient loses bits, and larger
// radices or small values need fewer of them. An idle front end moves the
// request from the holding register into the divider and, once the last digit
// is out, hands the layout to the queue, waiting while the queue is full. The
// back end then emits one character per cycle (up to 64) while rsp_ch.ready
// allows it. The divider and the emitter overlap through the queue, so the
// sustained throughput is set by the slower of the two. A one-entry input
// holding register takes the next request while the divider is busy.
// Reset (synchronous, active high) empties the holding register, queue and
// output register; no request is in flight afterwards. When the receiver holds
// rsp_ch.ready low the output register holds its character, the queue fills,
// and then req_ch.ready drops.
module padded_radix_number_formatter_top #(
   parameter int VALUE_BITS  = prnf_pkg::VALUE_BITS_DEF,
   parameter int QUEUE_DEPTH = prnf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   prnf_req_if.sink    req_ch,
   prnf_rsp_if.source  rsp_ch
);

   localparam int DIGITS  = (VALUE_BITS + 2) / 3;
   localparam int DIG_W   = DIGITS * 4;
   localparam int CTL_W   = $bits(prnf_pkg::prnf_ctl_type);
   localparam int ENTRY_W = CTL_W + DIG_W;

   // Front to queue
   logic                   push_valid;
   prnf_pkg::prnf_ctl_type push_ctl;
   logic [DIG_W-1:0]       push_digits;
   logic                   queue_full;

   // Queue to back
   logic [ENTRY_W-1:0]     head_entry;
   prnf_pkg::prnf_ctl_type head_ctl;
   logic [DIG_W-1:0]       head_digits;
   logic                   head_empty;
   logic                   pop;

   // Accept, divide, lay out segments.
   prnf_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .push_valid  (push_valid),
      .push_ctl    (push_ctl),
      .push_digits (push_digits),
      .queue_full  (queue_full)
   );

   // Decouple the divider from the emitter.
   prnf_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_ctl, push_digits}),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (head_entry),
      .empty     (head_empty)
   );

   assign head_ctl    = prnf_pkg::prnf_ctl_type'(head_entry[ENTRY_W-1 -: CTL_W]);
   assign head_digits = head_entry[DIG_W-1:0];

   // Emit one character per cycle into the response register while rsp_ch accepts.
   prnf_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_ctl    (head_ctl),
      .head_digits (head_digits),
      .head_empty  (head_empty),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

   // An empty conversion is a single final response with no count.
   a_empty_is_final : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_empty |-> rsp_ch.is_last && rsp_ch.total_count == '0)
      else $error("empty response not final or has a count");

   // Only the final response carries the count.
   a_count_on_last : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.is_last |-> rsp_ch.total_count == '0)
      else $error("count on a non-final response");

   // A non-empty conversion reports between 1 and 64 characters.
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_last && !rsp_ch.is_empty |->
      rsp_ch.total_count != '0 && rsp_ch.total_count <= 7'd64)
      else $error("final count out of range");

   // Nothing is presented right after reset.
   a_quiet_after_reset : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");

endmodule
